FILE: design/rdes_pkg.sv
`default_nettype none
package rdes_pkg;

  // Channel and field widths fixed by the stream format
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned FIELD_W = 12;

  // Threshold value after reset
  localparam logic [CHAN_W-1:0] THRESH_RESET = 8'd250;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [FIELD_W-1:0] field_t;

  // One pixel beat
  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  frame_start;
    logic  row_end;
  } pixel_t;

  // One dark-extent result beat
  typedef struct packed {
    field_t row_number;
    field_t left_column;
    field_t right_column;
    field_t hit_index;
  } result_t;

endpackage
`default_nettype wire

FILE: design/rdes_stream_if.sv
`default_nettype none
interface rdes_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/row_dark_extent_scanner_core.sv
// Path: the row_end pixel beat goes through the input register, then the result
// register; result valid is registered, and a stalled result can hold the beat back.
// Throughput: one pixel beat per cycle; ready runs back combinationally, so a
// stalled result beat stalls the input once the input register is also full.
// Reset: rst_ni asynchronous, active low; clears counters, extent and valids,
// threshold returns to 250.
`default_nettype none
module row_dark_extent_scanner_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        dark_threshold_we_i,
  input  wire [rdes_pkg::CHAN_W-1:0] dark_threshold_i,
  rdes_stream_if.sink                pix_i,
  rdes_stream_if.source              res_o
);

  rdes_stream_if #(.T(rdes_pkg::pixel_t)) stg ();

  // Pixel input register
  rdes_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .pix_o  (stg)
  );

  // Scan logic and result register
  rdes_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .dark_threshold_we_i (dark_threshold_we_i),
    .dark_threshold_i    (dark_threshold_i),
    .pix_i               (stg),
    .res_o               (res_o)
  );

endmodule
`default_nettype wire

FILE: design/rdes_in_stage.sv
`default_nettype none
// Input register: holds one pixel beat until the scan stage takes it
module rdes_in_stage (
  input  wire    clk_i,
  input  wire    rst_ni,
  rdes_stream_if.sink   pix_i,
  rdes_stream_if.source pix_o
);

  logic            vld_q, vld_d;
  rdes_pkg::pixel_t pix_q;
  logic            take;

  // Open when empty or when the held beat moves on this cycle
  assign pix_i.ready = !vld_q || pix_o.ready;
  assign take        = pix_i.valid && pix_i.ready;

  always_comb begin
    if (take) begin
      vld_d = 1'b1;
    end else if (pix_o.ready) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (take) begin
      pix_q <= pix_i.data;
    end
  end

  assign pix_o.valid = vld_q;
  assign pix_o.data  = pix_q;

endmodule
`default_nettype wire

FILE: design/rdes_scan.sv
`default_nettype none
// Row scan: dark test, per-row extent tracking, counters and result register
module rdes_scan #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      dark_threshold_we_i,
  input  wire [rdes_pkg::CHAN_W-1:0] dark_threshold_i,
  rdes_stream_if.sink              pix_i,
  rdes_stream_if.source            res_o
);

  localparam int unsigned COL_W = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [COL_W-1:0] COL_TOP = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_TOP = ROW_W'(MAX_HEIGHT - 1);

  rdes_pkg::chan_t  thresh_q;
  logic [COL_W-1:0] col_q, col_d, col_e;
  logic [ROW_W-1:0] row_q, row_d, row_e;
  logic [ROW_W-1:0] hit_q, hit_d, hit_e;
  logic             seen_q, seen_d, seen_e, seen_n;
  logic [COL_W-1:0] first_q, first_d;
  logic [COL_W-1:0] last_q, last_d;
  logic             res_vld_q, res_vld_d;
  rdes_pkg::result_t res_q, res_d;

  logic             out_free, take, dark, emit;
  rdes_pkg::pixel_t px;

  assign px       = pix_i.data;
  assign out_free = !res_vld_q || res_o.ready;
  assign take     = pix_i.valid && out_free;
  assign pix_i.ready = out_free;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= rdes_pkg::THRESH_RESET;
    end else if (dark_threshold_we_i) begin
      thresh_q <= dark_threshold_i;
    end
  end

  // Frame start clears counters before the pixel is looked at
  always_comb begin
    col_e  = px.frame_start ? '0 : col_q;
    row_e  = px.frame_start ? '0 : row_q;
    hit_e  = px.frame_start ? '0 : hit_q;
    seen_e = px.frame_start ? 1'b0 : seen_q;
  end

  assign dark = (px.red < thresh_q) && (px.green < thresh_q) && (px.blue < thresh_q);
  assign seen_n = seen_e || dark;
  assign emit   = px.row_end && seen_n;

  // Next state for one beat
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    hit_d   = hit_q;
    seen_d  = seen_q;
    first_d = first_q;
    last_d  = last_q;
    res_d   = res_q;
    if (take) begin
      first_d = (dark && !seen_e) ? col_e : first_q;
      last_d  = dark ? col_e : last_q;
      res_d.row_number   = rdes_pkg::field_t'(row_e);
      res_d.left_column  = rdes_pkg::field_t'(first_d);
      res_d.right_column = rdes_pkg::field_t'(last_d);
      res_d.hit_index    = rdes_pkg::field_t'(hit_e);
      if (px.row_end) begin
        col_d  = '0;
        seen_d = 1'b0;
        row_d  = (row_e == ROW_TOP) ? row_e : row_e + 1'b1;
        if (seen_n) begin
          hit_d = (hit_e == ROW_TOP) ? hit_e : hit_e + 1'b1;
        end else begin
          hit_d = hit_e;
        end
      end else begin
        col_d  = (col_e == COL_TOP) ? col_e : col_e + 1'b1;
        row_d  = row_e;
        hit_d  = hit_e;
        seen_d = seen_n;
      end
    end
  end

  // Result valid: load on a hit, drop once taken
  always_comb begin
    if (take && emit) begin
      res_vld_d = 1'b1;
    end else if (res_o.ready) begin
      res_vld_d = 1'b0;
    end else begin
      res_vld_d = res_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      hit_q     <= '0;
      seen_q    <= 1'b0;
      first_q   <= '0;
      last_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      hit_q     <= hit_d;
      seen_q    <= seen_d;
      first_q   <= first_d;
      last_q    <= last_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (take && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

endmodule
`default_nettype wire

FILE: design/rdes_checker.sv
`default_nettype none
module rdes_checker #(
  parameter int unsigned MaxWidth  = 4096,
  parameter int unsigned MaxHeight = 4096
) (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      res_valid_i,
  input wire                      res_ready_i,
  input wire rdes_pkg::result_t   res_data_i
);

  // Stalled result beat holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_data_i))
    else $error("result beat changed while stalled");

  // No result once reset has been seen
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |=> !res_valid_i)
    else $error("result valid during reset");

  // Extent is ordered when columns fit the field
  a_extent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (MaxWidth > 4096) ||
                    (res_data_i.left_column <= res_data_i.right_column))
    else $error("left column past right column");

  // Hit rows never outnumber rows seen
  a_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (MaxHeight > 4096) ||
                    (res_data_i.hit_index <= res_data_i.row_number))
    else $error("hit index beyond row number");

endmodule

bind row_dark_extent_scanner_core rdes_checker #(
  .MaxWidth  (MAX_WIDTH),
  .MaxHeight (MAX_HEIGHT)
) u_rdes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .res_data_i  (res_o.data)
);
`default_nettype wire
